// ----- src/hrr_pkg.sv -----
// Shared types and constants for the HID request reassembler.
// No dependencies; used by every module of the block.
package hrr_pkg;

   localparam int ReportBytes = 64;
   localparam int PayloadMax  = 1024;
   localparam int InitChunk   = 57;
   localparam int ContChunk   = 59;
   localparam int InitFrom    = 7;
   localparam int ContFrom    = 5;
   localparam int HeaderBytes = 7;

   localparam logic [6:0] SeqMask = 7'h7F;

   localparam logic [1:0] KIND_DONE  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic ERR_FORMAT  = 1'b0;
   localparam logic ERR_CHANNEL = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       end_of_report;
      logic [9:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  request_code;
      logic [10:0] request_length;
      logic        error_code;
      logic [7:0]  read_data;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_BYTE,
      OP_LAST
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic [9:0] read_index;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_q_type;

endpackage

// ----- src/hid_request_reassembler.sv -----
// Top level of the HID request reassembler.
// Depends on hrr_pkg, hrr_front and hrr_back.
//
//  - req_* channel: valid/stall. Each item is either one report byte
//    (command 0, end_of_report marks the last byte) or a read of one byte
//    of the last completed request (command 1, read_index).
//  - rsp_* channel: valid/stall. At most one item per input item: request
//    complete (code and length), error, or read data.
//  - csr_write_enable/csr_write_data load the expected channel id; write it
//    only while the block is idle.
//  - Back-end flow: a report byte is taken without leaving S_IDLE; a read
//    passes through S_READ. The last byte of a full report goes through
//    S_DECIDE and, if a copy starts, alternates S_COPY_RD and S_COPY_WR per
//    copied chunk byte (up to 59), stage reads feeding request store writes.
//  - A two-entry queue lets the front keep taking items while the back
//    copies; req_stall rises only when that queue is full.
//  - A read result passes through the queue, S_READ and the output register.
//  - Reset empties the queue, drops any partial report or assembly and
//    clears the channel id. While rsp_stall is high the result holds in
//    the output register and the back end waits before the next item.
module hid_request_reassembler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hrr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hrr_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data
);

   hrr_pkg::work_q_type q_head;
   logic                q_pop;

   // front: accept and classify into the queue
   hrr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_head      (q_head),
      .q_pop       (q_pop)
   );

   // back: stage, check, copy, read, and hold the result register
   hrr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ----- src/hrr_front.sv -----
// Front end: accepts input items, classifies them and queues them.
// Depends on hrr_pkg.
module hrr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hrr_pkg::req_payload_type req_payload,
   output hrr_pkg::work_q_type      q_head,
   input  logic                     q_pop
);

   hrr_pkg::work_type entry_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              accept;
   hrr_pkg::work_type classified;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   // classify: read, plain byte, or last byte of a report
   always_comb begin
      classified.data_byte  = req_payload.data_byte;
      classified.read_index = req_payload.read_index;
      if (req_payload.command) begin
         classified.op = hrr_pkg::OP_READ;
      end else if (req_payload.end_of_report) begin
         classified.op = hrr_pkg::OP_LAST;
      end else begin
         classified.op = hrr_pkg::OP_BYTE;
      end
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.work  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, accept} - {1'b0, q_pop};
      end
   end

endmodule

// ----- src/hrr_back.sv -----
// Back end: stages reports, checks headers, copies chunks, serves reads.
// Depends on hrr_pkg; holds the report stage and request store memories.
module hrr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data,
   input  hrr_pkg::work_q_type      q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hrr_pkg::rsp_payload_type rsp_payload
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DECIDE,
      S_COPY_RD,
      S_COPY_WR
   } state_type;

   state_type   state_ff;
   logic [31:0] channel_id_ff;
   logic [6:0]  fill_ff;
   logic [7:0]  hdr_ff [hrr_pkg::HeaderBytes];
   logic        assembling_ff;
   logic [10:0] total_ff;
   logic [10:0] recv_ff;
   logic [6:0]  seq_ff;
   logic [6:0]  code_ff;
   logic [10:0] readable_ff;
   logic [5:0]  src_ff;
   logic [5:0]  left_ff;
   logic        read_ok_ff;
   logic        out_valid_ff;
   hrr_pkg::rsp_payload_type out_ff;

   logic [7:0]  stage_mem [hrr_pkg::ReportBytes];
   logic [7:0]  stage_rd_ff;
   logic [7:0]  store_mem [hrr_pkg::PayloadMax];
   logic [7:0]  store_rd_ff;

   logic        out_free;
   logic        stage_we;
   logic        store_we;
   logic [31:0] header_cid;
   logic [15:0] header_count;
   logic [10:0] left_total;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign q_pop       = (state_ff == S_IDLE) && q_head.valid && out_free;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assign stage_we = q_pop && (q_head.work.op != hrr_pkg::OP_READ) &&
                     (fill_ff < 7'(hrr_pkg::ReportBytes));
   assign store_we = (state_ff == S_COPY_WR);

   assign header_cid   = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]};
   assign header_count = {hdr_ff[5], hdr_ff[6]};
   assign left_total   = total_ff - recv_ff;

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[fill_ff[5:0]] <= q_head.work.data_byte;
      end
      stage_rd_ff <= stage_mem[src_ff];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[recv_ff[9:0]] <= stage_rd_ff;
      end
      store_rd_ff <= store_mem[q_head.work.read_index];
   end

   // header bytes are also kept in flops so S_DECIDE needs no memory read
   always_ff @(posedge clock) begin
      if (stage_we && (fill_ff < 7'(hrr_pkg::HeaderBytes))) begin
         hdr_ff[fill_ff[2:0]] <= q_head.work.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         channel_id_ff <= '0;
         fill_ff       <= '0;
         assembling_ff <= 1'b0;
         total_ff      <= '0;
         recv_ff       <= '0;
         seq_ff        <= '0;
         code_ff       <= '0;
         readable_ff   <= '0;
         src_ff        <= '0;
         left_ff       <= '0;
         read_ok_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            channel_id_ff <= csr_write_data;
         end
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  case (q_head.work.op)
                     hrr_pkg::OP_READ: begin
                        read_ok_ff <= {1'b0, q_head.work.read_index} < readable_ff;
                        state_ff   <= S_READ;
                     end
                     hrr_pkg::OP_LAST: begin
                        fill_ff <= '0;
                        // full once this byte brings the count to a report
                        if (fill_ff >= 7'(hrr_pkg::ReportBytes - 1)) begin
                           state_ff <= S_DECIDE;
                        end
                     end
                     default: begin
                        if (stage_we) begin
                           fill_ff <= fill_ff + 7'd1;
                        end
                     end
                  endcase
               end
            end
            S_READ: begin
               out_ff       <= '{kind: hrr_pkg::KIND_READ,
                                 read_data: read_ok_ff ? store_rd_ff : 8'd0,
                                 default: '0};
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_DECIDE: begin
               state_ff <= S_IDLE;
               if (header_cid != channel_id_ff) begin
                  assembling_ff <= 1'b0;
                  total_ff      <= '0;
                  recv_ff       <= '0;
                  seq_ff        <= '0;
                  code_ff       <= '0;
                  readable_ff   <= '0;
                  out_ff        <= '{kind: hrr_pkg::KIND_ERROR,
                                     error_code: hrr_pkg::ERR_CHANNEL,
                                     default: '0};
                  out_valid_ff  <= 1'b1;
               end else if (hdr_ff[4][7]) begin
                  if (header_count > 16'(hrr_pkg::PayloadMax)) begin
                     assembling_ff <= 1'b0;
                     total_ff      <= '0;
                     recv_ff       <= '0;
                     seq_ff        <= '0;
                     code_ff       <= '0;
                     readable_ff   <= '0;
                     out_ff        <= '{kind: hrr_pkg::KIND_ERROR,
                                        error_code: hrr_pkg::ERR_FORMAT,
                                        default: '0};
                     out_valid_ff  <= 1'b1;
                  end else begin
                     code_ff     <= hdr_ff[4][6:0];
                     total_ff    <= header_count[10:0];
                     recv_ff     <= '0;
                     seq_ff      <= '0;
                     readable_ff <= '0;
                     src_ff      <= 6'(hrr_pkg::InitFrom);
                     left_ff     <= (header_count > 16'(hrr_pkg::InitChunk)) ?
                                    6'(hrr_pkg::InitChunk) : header_count[5:0];
                     state_ff    <= S_COPY_RD;
                  end
               end else if (assembling_ff) begin
                  if ((hdr_ff[4][6:0] & hrr_pkg::SeqMask) != seq_ff) begin
                     assembling_ff <= 1'b0;
                     total_ff      <= '0;
                     recv_ff       <= '0;
                     seq_ff        <= '0;
                     code_ff       <= '0;
                     readable_ff   <= '0;
                     out_ff        <= '{kind: hrr_pkg::KIND_ERROR,
                                        error_code: hrr_pkg::ERR_FORMAT,
                                        default: '0};
                     out_valid_ff  <= 1'b1;
                  end else begin
                     seq_ff   <= (seq_ff + 7'd1) & hrr_pkg::SeqMask;
                     src_ff   <= 6'(hrr_pkg::ContFrom);
                     left_ff  <= (left_total > 11'(hrr_pkg::ContChunk)) ?
                                 6'(hrr_pkg::ContChunk) : left_total[5:0];
                     state_ff <= S_COPY_RD;
                  end
               end
            end
            S_COPY_RD: begin
               if (left_ff != 6'd0) begin
                  state_ff <= S_COPY_WR;
               end else begin
                  state_ff <= S_IDLE;
                  if (recv_ff >= total_ff) begin
                     assembling_ff <= 1'b0;
                     readable_ff   <= recv_ff;
                     out_ff        <= '{kind: hrr_pkg::KIND_DONE,
                                        request_code: code_ff,
                                        request_length: recv_ff,
                                        default: '0};
                     out_valid_ff  <= 1'b1;
                  end else begin
                     assembling_ff <= 1'b1;
                  end
               end
            end
            S_COPY_WR: begin
               recv_ff  <= recv_ff + 11'd1;
               src_ff   <= src_ff + 6'd1;
               left_ff  <= left_ff - 6'd1;
               state_ff <= S_COPY_RD;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for hid_request_reassembler: report bytes and reads in,
// completion/error/read results out, checked against typed-in or predicted ones.
// Depends on hrr_pkg and the hid_request_reassembler RTL.
module tb;

   typedef enum logic {ROW_READ, ROW_REPORT} row_act_type;

   // One directed stimulus row: a single read or a whole report.
   typedef struct {
      row_act_type              act;
      logic [31:0]              cid;
      logic [7:0]               hdr;
      logic [15:0]              count;
      int                       nbytes;
      logic [9:0]               idx;
      bit                       typed;
      hrr_pkg::rsp_payload_type want;
   } row_type;

   // What the sender promises for an item: a typed-in result, or none.
   typedef struct {
      bit                       typed;
      hrr_pkg::rsp_payload_type want;
   } note_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   hrr_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   hrr_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable = 1'b0;
   logic [31:0]              csr_write_data = '0;

   // Predictor state: staged report, request store and assembly progress.
   logic [7:0]  rx_stage [hrr_pkg::ReportBytes];
   int          rx_fill;
   logic [7:0]  msg_store [hrr_pkg::PayloadMax];
   bit          msg_busy;
   int          msg_total, msg_got, msg_ready;
   logic [6:0]  msg_seq, msg_code;
   logic [31:0] exp_chan;

   note_type                 note_q [$];
   hrr_pkg::rsp_payload_type result_q [$];

   int errors = 0;
   int items_in = 0;
   int results_out = 0;
   int messages = 0;
   bit quiet = 1'b0;       // no idling on either side
   bit calm = 1'b0;        // sender idling off for this stretch
   bit hold_req = 1'b0;    // ask the receiver for one long hold-off
   int hold_left = 0;
   int stall_left = 0;
   logic [31:0] chan_now = '0;

   row_type rows [11];

   hid_request_reassembler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Work out the result of one accepted item and advance the predictor.
   task automatic reassemble(input hrr_pkg::req_payload_type p, output bit got,
                             output hrr_pkg::rsp_payload_type r);
      logic [31:0] cid;
      logic [15:0] cnt;
      int          from, lim, n;
      got = 1'b0;
      r = '0;
      if (p.command) begin
         got = 1'b1;
         r.kind = hrr_pkg::KIND_READ;
         if (int'(p.read_index) < msg_ready)
            r.read_data = msg_store[p.read_index];
         return;
      end
      if (rx_fill < hrr_pkg::ReportBytes) begin
         rx_stage[rx_fill] = p.data_byte;
         rx_fill++;
      end
      if (!p.end_of_report)
         return;
      if (rx_fill < hrr_pkg::ReportBytes) begin
         // short report: drop it silently
         rx_fill = 0;
         return;
      end
      rx_fill = 0;
      cid = {rx_stage[0], rx_stage[1], rx_stage[2], rx_stage[3]};
      if (cid != exp_chan) begin
         msg_busy = 0; msg_total = 0; msg_got = 0; msg_seq = 0; msg_code = 0;
         msg_ready = 0;
         got = 1'b1;
         r.kind = hrr_pkg::KIND_ERROR;
         r.error_code = hrr_pkg::ERR_CHANNEL;
         return;
      end
      if (rx_stage[4][7]) begin
         cnt = {rx_stage[5], rx_stage[6]};
         if (cnt > hrr_pkg::PayloadMax) begin
            msg_busy = 0; msg_total = 0; msg_got = 0; msg_seq = 0; msg_code = 0;
            msg_ready = 0;
            got = 1'b1;
            r.kind = hrr_pkg::KIND_ERROR;
            r.error_code = hrr_pkg::ERR_FORMAT;
            return;
         end
         // INIT restarts the request even if one is in progress
         msg_code = rx_stage[4][6:0];
         msg_total = cnt;
         msg_got = 0;
         msg_seq = 0;
         msg_ready = 0;
         from = hrr_pkg::InitFrom;
         lim = hrr_pkg::InitChunk;
      end else begin
         if (!msg_busy)
            return;
         if (rx_stage[4][6:0] != msg_seq) begin
            msg_busy = 0; msg_total = 0; msg_got = 0; msg_seq = 0; msg_code = 0;
            msg_ready = 0;
            got = 1'b1;
            r.kind = hrr_pkg::KIND_ERROR;
            r.error_code = hrr_pkg::ERR_FORMAT;
            return;
         end
         msg_seq = (msg_seq + 7'd1) & hrr_pkg::SeqMask;
         from = hrr_pkg::ContFrom;
         lim = hrr_pkg::ContChunk;
      end
      n = (msg_total - msg_got > lim) ? lim : msg_total - msg_got;
      for (int k = 0; k < n; k++)
         if (msg_got + k < hrr_pkg::PayloadMax)
            msg_store[msg_got + k] = (from + k < hrr_pkg::ReportBytes) ?
                                     rx_stage[from + k] : 8'h00;
      msg_got += n;
      msg_busy = 1'b1;
      if (msg_got >= msg_total) begin
         msg_busy = 1'b0;
         msg_ready = msg_got;
         got = 1'b1;
         r.kind = hrr_pkg::KIND_DONE;
         r.request_code = msg_code;
         r.request_length = msg_got[10:0];
      end
   endtask

   // Monitor: predict on every accepted item, check every accepted result.
   always @(posedge clock) begin
      note_type                 nt;
      bit                       got;
      hrr_pkg::rsp_payload_type r, w;
      if (reset) begin
         rx_fill = 0;
         msg_busy = 0; msg_total = 0; msg_got = 0; msg_seq = 0; msg_code = 0;
         msg_ready = 0;
         exp_chan = '0;
      end else begin
         if (csr_write_enable)
            exp_chan = csr_write_data;
         if (req_valid && !req_stall) begin
            nt = note_q.pop_front();
            reassemble(req_payload, got, r);
            items_in++;
            if (nt.typed)
               result_q.push_back(nt.want);
            else if (got)
               result_q.push_back(r);
         end
         if (rsp_valid && !rsp_stall) begin
            results_out++;
            if (result_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result %p", rsp_payload);
            end else begin
               w = result_q.pop_front();
               if (rsp_payload.kind !== w.kind ||
                   rsp_payload.request_code !== w.request_code ||
                   rsp_payload.request_length !== w.request_length ||
                   rsp_payload.error_code !== w.error_code ||
                   rsp_payload.read_data !== w.read_data) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %p, got %p", w, rsp_payload);
               end
            end
         end
      end
   end

   // Receiver: short random stall bursts, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one item and hold it until accepted; gaps come as short bursts.
   task automatic send_item(input hrr_pkg::req_payload_type p, input bit typed,
                            input hrr_pkg::rsp_payload_type want);
      note_type nt;
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      nt.typed = typed;
      nt.want = want;
      note_q.push_back(nt);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_read(input logic [9:0] idx, input bit typed,
                            input hrr_pkg::rsp_payload_type want);
      hrr_pkg::req_payload_type p;
      p = '0;
      p.command = 1'b1;
      p.data_byte = $urandom;
      p.end_of_report = $urandom;
      p.read_index = idx;
      send_item(p, typed, want);
   endtask

   // Send one report: channel id, header byte, count, then random bytes.
   task automatic send_report(input logic [31:0] cid, input logic [7:0] hdr,
                              input logic [15:0] cnt, input int nbytes,
                              input bit typed, input hrr_pkg::rsp_payload_type want);
      hrr_pkg::req_payload_type p;
      for (int i = 0; i < nbytes; i++) begin
         p = '0;
         p.read_index = $urandom;
         case (i)
            0: p.data_byte = cid[31:24];
            1: p.data_byte = cid[23:16];
            2: p.data_byte = cid[15:8];
            3: p.data_byte = cid[7:0];
            4: p.data_byte = hdr;
            5: p.data_byte = cnt[15:8];
            6: p.data_byte = cnt[7:0];
            default: p.data_byte = $urandom;
         endcase
         p.end_of_report = (i == nbytes - 1);
         send_item(p, typed && (i == nbytes - 1), want);
      end
   endtask

   // A well-formed request of len bytes, now and then broken on purpose.
   task automatic send_message(input int len);
      int         left, nb;
      logic [6:0] seq;
      calm = ($urandom_range(0, 2) == 0);
      messages++;
      nb = ($urandom_range(0, 7) == 0) ? hrr_pkg::ReportBytes + $urandom_range(1, 6)
                                       : hrr_pkg::ReportBytes;
      send_report(chan_now, {1'b1, 7'($urandom)}, len[15:0], nb, 1'b0, '0);
      left = len - hrr_pkg::InitChunk;
      seq = '0;
      while (left > 0) begin
         case ($urandom_range(0, 29))
            0: begin
               send_report(chan_now, {1'b0, seq + 7'($urandom_range(1, 127))},
                           $urandom, hrr_pkg::ReportBytes, 1'b0, '0);
               left = 0;
            end
            1: begin
               send_report(~chan_now, {1'b0, seq}, $urandom, hrr_pkg::ReportBytes,
                           1'b0, '0);
               left = 0;
            end
            2: send_report(chan_now, {1'b0, seq}, $urandom, $urandom_range(1, 63),
                           1'b0, '0);
            default: begin
               send_report(chan_now, {1'b0, seq}, $urandom, hrr_pkg::ReportBytes,
                           1'b0, '0);
               left -= hrr_pkg::ContChunk;
               seq++;
            end
         endcase
      end
      repeat ($urandom_range(1, 4))
         send_read(($urandom_range(0, 3) == 0) ? 10'($urandom) :
                   10'(($urandom_range(0, len + 3) > 1023) ? 1023 : $urandom_range(0, len + 3)),
                   1'b0, '0);
   endtask

   // Let every expected result arrive, then wait out any copy still running.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (result_q.size() != 0 || note_q.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_channel(input logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      chan_now = value;
   endtask

   task automatic random_phase(input int target);
      int r;
      while (items_in < target) begin
         r = $urandom_range(0, 19);
         if (r < 8) begin
            send_message(($urandom_range(0, 3) == 0) ? $urandom_range(58, 180)
                                                     : $urandom_range(0, 57));
         end else if (r < 9) begin
            send_report(chan_now, {1'b1, 7'($urandom)}, 16'($urandom_range(1025, 65535)),
                        hrr_pkg::ReportBytes, 1'b0, '0);
         end else if (r < 10) begin
            send_report($urandom, $urandom, $urandom, hrr_pkg::ReportBytes, 1'b0, '0);
         end else if (r < 11) begin
            send_report(chan_now, {1'b0, 7'($urandom)}, $urandom, hrr_pkg::ReportBytes,
                        1'b0, '0);
         end else if (r < 12) begin
            send_report(chan_now, $urandom, $urandom, $urandom_range(1, 63), 1'b0, '0);
         end else begin
            send_read($urandom, 1'b0, '0);
         end
      end
   endtask

   initial begin
      rows = '{
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd0,    1'b1,
            '{kind: hrr_pkg::KIND_READ, default: '0}},
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd1023, 1'b1,
            '{kind: hrr_pkg::KIND_READ, default: '0}},
         '{ROW_REPORT, 32'h0,        8'h80, 16'h0000, 10, 10'd0,    1'b0, '{default: '0}},
         '{ROW_REPORT, 32'hFFFFFFFF, 8'h80, 16'h0000, 64, 10'd0,    1'b1,
            '{kind: hrr_pkg::KIND_ERROR, error_code: hrr_pkg::ERR_CHANNEL, default: '0}},
         '{ROW_REPORT, 32'h0,        8'h80, 16'h0401, 64, 10'd0,    1'b1,
            '{kind: hrr_pkg::KIND_ERROR, error_code: hrr_pkg::ERR_FORMAT, default: '0}},
         '{ROW_REPORT, 32'h0,        8'hFF, 16'h0000, 64, 10'd0,    1'b1,
            '{kind: hrr_pkg::KIND_DONE, request_code: 7'h7F, default: '0}},
         '{ROW_REPORT, 32'h0,        8'h81, 16'h0005, 70, 10'd0,    1'b0, '{default: '0}},
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd0,    1'b0, '{default: '0}},
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd4,    1'b0, '{default: '0}},
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd5,    1'b1,
            '{kind: hrr_pkg::KIND_READ, default: '0}},
         '{ROW_READ,   32'h0,        8'h00, 16'h0000,  0, 10'd1023, 1'b1,
            '{kind: hrr_pkg::KIND_READ, default: '0}}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, channel id still at its reset value of zero.
      foreach (rows[i]) begin
         if (rows[i].act == ROW_READ)
            send_read(rows[i].idx, rows[i].typed, rows[i].want);
         else
            send_report(rows[i].cid, rows[i].hdr, rows[i].count, rows[i].nbytes,
                        rows[i].typed, rows[i].want);
      end

      // Random part on a fresh channel id. The receiver holds off while a
      // run of reads piles up behind the first result, so the input stalls.
      write_channel($urandom);
      hold_req = 1'b1;
      repeat (6) send_read(10'($urandom_range(0, 7)), 1'b0, '0);
      random_phase(items_in + 60);
      quiet = 1'b1;
      random_phase(items_in + 60);

      drain();
      $display("covered %0d items, %0d results, %0d requests across errors,",
               items_in, results_out, messages);
      $display("short and oversized reports, out of range reads and a long hold-off");
      if (errors == 0 && result_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, result_q.size());
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
src/hrr_pkg.sv
src/hrr_front.sv
src/hrr_back.sv
src/hid_request_reassembler.sv
tb/tb.sv
